@@ src/lgsl_pkg.sv @@
// Shared types and constants for the LED gain slew limiter.
// No dependencies.
package lgsl_pkg;

    localparam int GAIN_W = 13;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 13'd4096;
    // floor(x / 15625) = (x * RECIP_15625) >> 40 for any x below 2^26
    localparam logic [26:0] RECIP_15625 = 27'd70368745;
    localparam logic [47:0] CEIL_ADD = 48'd999999;
    localparam logic [63:0] DT_CAP = 64'd4096000000;
    localparam logic [47:0] P_CAP = 48'd4096000000;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_COMMIT = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;
    localparam logic [1:0] FUNC_READ = 2'd3;

    localparam logic CFG_SLEW = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] cur;
        logic [GAIN_W-1:0] goal;
    } t_entry;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_SNAP,
        OP_STEP
    } t_op;

    typedef struct packed {
        logic changed;
        logic remaining;
        logic nonunity;
        logic goal_nonunity;
        logic goal_differs;
    } t_head_stat;

endpackage

@@ src/led_gain_slew_limiter_unit.sv @@
// Write, read, commit and idle advance sweep the ring once and then strobe the result; a
// stepping advance first waits for the step unit (which skips its divide when the step caps),
// and one that sees time going backwards first passes through the calc state. One request
// at a time: busy stays high until the cycle after the strobe, and start is taken only in idle.
// Strobe o_valid lasts one cycle, no stall. Sync active-low reset: gains unity, flags idle.
// Depends on lgsl_pkg, lgsl_cell, lgsl_head, lgsl_step.
module led_gain_slew_limiter_unit #(
    parameter int LEDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_led_index,
    input  logic [15:0] i_target_gain,
    input  logic [63:0] i_now_us,
    input  logic        i_source_usable,
    input  logic        i_fail_open,
    input  logic [7:0]  i_segment_id,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_changed,
    output logic        o_is_settled,
    output logic        o_attenuated,
    output logic [12:0] o_gain_out
);
    localparam int CW = $clog2(LEDS + 1);
    localparam logic [CW-1:0] LAST = CW'(LEDS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CALC  = 5'b00010,
        S_DIV   = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        K_WRITE,
        K_READ,
        K_FO,
        K_REINIT,
        K_COMMIT,
        K_ADV_IDLE,
        K_ADV,
        K_ADV_BACK,
        K_ADV_STEP
    } t_kind;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0] r_slew;
    logic [8:0]  r_active;
    logic [7:0]  r_idx;
    logic [12:0] r_tgt;
    logic [63:0] r_now;
    logic [7:0]  r_seg_in;
    logic        r_fo_in;
    logic [63:0] r_dt;
    logic        r_back;
    logic [63:0] r_last, n_last;
    logic r_init, n_init, r_settled, n_settled, r_att, n_att;
    logic r_cur_fo, n_cur_fo, r_goal_fo, n_goal_fo, r_dirty, n_dirty;
    logic [7:0] r_seg, n_seg;
    lgsl_pkg::t_head_stat r_acc, n_acc;
    logic [12:0] r_gain, n_gain;
    logic r_valid, n_valid, r_chg, n_chg;

    logic [31:0] nact;
    logic        active, hit, sweeping, step_start, step_done, fo_req;
    logic [12:0] step;
    lgsl_pkg::t_op op;
    lgsl_pkg::t_entry ring [LEDS];
    lgsl_pkg::t_entry head_out;
    lgsl_pkg::t_head_stat stat;

    assign nact = (32'(r_active) > 32'(LEDS)) ? 32'(LEDS) : 32'(r_active);
    assign active = 32'(r_cnt) < nact;
    assign hit = 32'(r_cnt) == 32'(r_idx);
    assign sweeping = r_state == S_SWEEP;
    assign fo_req = !i_source_usable || i_fail_open;

    always_comb begin
        case (r_kind)
            K_WRITE: op = lgsl_pkg::OP_WRITE;
            K_FO, K_REINIT, K_ADV_BACK: op = lgsl_pkg::OP_SNAP;
            K_ADV_STEP: op = lgsl_pkg::OP_STEP;
            default: op = lgsl_pkg::OP_NONE;
        endcase
    end

    for (genvar k = 0; k < LEDS; k++) begin : g_ring
        lgsl_pkg::t_entry cell_in;
        if (k == LEDS - 1) begin : g_tail
            assign cell_in = head_out;
        end else begin : g_mid
            assign cell_in = ring[k+1];
        end
        lgsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (sweeping),
            .i_ent   (cell_in),
            .o_ent   (ring[k])
        );
    end

    lgsl_head u_head (
        .i_op     (op),
        .i_ent    (ring[0]),
        .i_hit    (hit),
        .i_active (active),
        .i_target (r_tgt),
        .i_step   (step),
        .o_ent    (head_out),
        .o_stat   (stat)
    );

    assign step_start = (r_state == S_CALC) && !r_back;

    lgsl_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (step_start),
        .i_dt    (r_dt),
        .i_slew  (r_slew),
        .o_done  (step_done),
        .o_step  (step)
    );

    always_comb begin
        n_state = r_state;
        n_kind = r_kind;
        n_cnt = r_cnt;
        n_last = r_last;
        n_init = r_init;
        n_settled = r_settled;
        n_att = r_att;
        n_cur_fo = r_cur_fo;
        n_goal_fo = r_goal_fo;
        n_dirty = r_dirty;
        n_seg = r_seg;
        n_acc = r_acc;
        n_gain = r_gain;
        n_valid = 1'b0;
        n_chg = r_chg;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cnt = '0;
                    n_acc = '0;
                    n_gain = '0;
                    n_chg = 1'b0;
                    n_state = S_SWEEP;
                    case (i_func)
                        lgsl_pkg::FUNC_WRITE: n_kind = K_WRITE;
                        lgsl_pkg::FUNC_READ: n_kind = K_READ;
                        lgsl_pkg::FUNC_COMMIT: begin
                            if (fo_req) n_kind = K_FO;
                            else if (!r_init || r_cur_fo || r_seg != i_segment_id)
                                n_kind = K_REINIT;
                            else n_kind = K_COMMIT;
                        end
                        default: begin
                            if (!r_init || r_settled || r_goal_fo) begin
                                n_kind = K_ADV_IDLE;
                            end else begin
                                n_kind = K_ADV;
                                n_state = S_CALC;
                            end
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (r_back) begin
                    n_kind = K_ADV_BACK;
                    n_state = S_SWEEP;
                end else begin
                    n_kind = K_ADV_STEP;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (step_done) n_state = S_SWEEP;
            end
            S_SWEEP: begin
                n_acc = r_acc | stat;
                if (r_kind == K_READ && hit) n_gain = ring[0].cur;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST) begin
                    n_state = S_DONE;
                    n_valid = 1'b1;
                    case (r_kind)
                        K_WRITE: begin
                            if (n_acc.goal_differs) n_dirty = 1'b1;
                        end
                        K_FO: begin
                            n_chg = r_dirty || r_att;
                            n_dirty = 1'b0;
                            n_goal_fo = 1'b1;
                            n_cur_fo = 1'b1;
                            n_seg = r_seg_in;
                            n_init = 1'b1;
                            n_settled = 1'b1;
                            n_att = 1'b0;
                            n_last = r_now;
                        end
                        K_REINIT: begin
                            n_chg = 1'b1;
                            n_dirty = 1'b0;
                            n_goal_fo = 1'b0;
                            n_cur_fo = 1'b0;
                            n_seg = r_seg_in;
                            n_init = 1'b1;
                            n_att = 1'b0;
                            n_last = r_now;
                            n_settled = !n_acc.goal_nonunity;
                        end
                        K_COMMIT: begin
                            n_chg = r_dirty;
                            n_dirty = 1'b0;
                            n_goal_fo = r_fo_in;
                            if (r_dirty) n_settled = 1'b0;
                        end
                        K_ADV_BACK: begin
                            n_chg = 1'b1;
                            n_cur_fo = 1'b0;
                            n_att = 1'b0;
                            n_settled = !n_acc.goal_nonunity;
                            n_last = r_now;
                        end
                        K_ADV_STEP: begin
                            n_chg = n_acc.changed;
                            n_cur_fo = 1'b0;
                            n_att = n_acc.nonunity;
                            n_settled = !n_acc.remaining;
                            n_last = r_now;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_slew <= '0;
            r_active <= 9'd256;
            r_last <= '0;
            r_init <= 1'b0;
            r_settled <= 1'b1;
            r_att <= 1'b0;
            r_cur_fo <= 1'b0;
            r_goal_fo <= 1'b0;
            r_dirty <= 1'b0;
            r_seg <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last <= n_last;
            r_init <= n_init;
            r_settled <= n_settled;
            r_att <= n_att;
            r_cur_fo <= n_cur_fo;
            r_goal_fo <= n_goal_fo;
            r_dirty <= n_dirty;
            r_seg <= n_seg;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lgsl_pkg::CFG_SLEW: r_slew <= i_cfg_data;
                    lgsl_pkg::CFG_ACTIVE: r_active <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
        end
        r_kind <= n_kind;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_gain <= n_gain;
        r_chg <= n_chg;
        if (r_state == S_IDLE && start) begin
            r_idx <= i_led_index;
            r_tgt <= (i_target_gain > 16'(lgsl_pkg::UNITY_GAIN)) ?
                     lgsl_pkg::UNITY_GAIN : i_target_gain[12:0];
            r_now <= i_now_us;
            r_seg_in <= i_segment_id;
            r_fo_in <= fo_req;
            r_dt <= i_now_us - r_last;
            r_back <= i_now_us < r_last;
        end
    end

    assign busy = r_state != S_IDLE;
    assign o_valid = r_valid;
    assign o_changed = r_chg;
    assign o_is_settled = r_settled;
    assign o_attenuated = r_att;
    assign o_gain_out = r_gain;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_cnt == LAST) |=> (o_valid && r_state == S_DONE))
        else $error("sweep did not end in a result");
    a_fo_not_att: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_fo |-> !r_att)
        else $error("attenuated while in fail-open");
    a_gain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_kind != K_READ) |-> (o_gain_out == 13'd0))
        else $error("gain out on non-read request");
`endif
endmodule

@@ src/lgsl_cell.sv @@
// One cell of the gain ring: holds one LED entry, takes its neighbor's entry when shifting.
// Depends on lgsl_pkg.
module lgsl_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  lgsl_pkg::t_entry i_ent,
    output lgsl_pkg::t_entry o_ent
);
    lgsl_pkg::t_entry r_ent;
    lgsl_pkg::t_entry n_ent;

    always_comb begin
        n_ent = i_shift ? i_ent : r_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.cur <= lgsl_pkg::UNITY_GAIN;
            r_ent.goal <= lgsl_pkg::UNITY_GAIN;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_ent = r_ent;
endmodule

@@ src/lgsl_head.sv @@
// Head of the ring: applies write, snap or slew step to the entry passing by.
// Depends on lgsl_pkg.
module lgsl_head (
    input  lgsl_pkg::t_op       i_op,
    input  lgsl_pkg::t_entry    i_ent,
    input  logic                i_hit,
    input  logic                i_active,
    input  logic [12:0]         i_target,
    input  logic [12:0]         i_step,
    output lgsl_pkg::t_entry    o_ent,
    output lgsl_pkg::t_head_stat o_stat
);
    logic [13:0] sum;
    logic [12:0] diff;
    logic [12:0] stepped;

    always_comb begin
        sum = {1'b0, i_ent.cur} + {1'b0, i_step};
        diff = i_ent.cur - i_ent.goal;
        if (i_ent.cur < i_ent.goal) begin
            stepped = (sum >= {1'b0, i_ent.goal}) ? i_ent.goal : sum[12:0];
        end else begin
            stepped = (diff <= i_step) ? i_ent.goal : i_ent.cur - i_step;
        end
    end

    always_comb begin
        o_ent = i_ent;
        case (i_op)
            lgsl_pkg::OP_WRITE: begin
                if (i_hit) o_ent.goal = i_target;
            end
            lgsl_pkg::OP_SNAP: begin
                o_ent.cur = lgsl_pkg::UNITY_GAIN;
            end
            lgsl_pkg::OP_STEP: begin
                if (i_active) o_ent.cur = stepped;
            end
            default: begin
            end
        endcase
        o_stat.changed = o_ent.cur != i_ent.cur;
        o_stat.remaining = i_active && (o_ent.cur != o_ent.goal);
        o_stat.nonunity = i_active && (o_ent.cur != lgsl_pkg::UNITY_GAIN);
        o_stat.goal_nonunity = i_active && (o_ent.goal != lgsl_pkg::UNITY_GAIN);
        o_stat.goal_differs = i_hit && (i_ent.goal != i_target);
    end
endmodule

@@ src/lgsl_step.sv @@
// Step limit unit: ceil(slew * dt / 1e6) capped at unity, or unity for a zero slew; one
// multiply, then a shift by 6 and a reciprocal multiply for the divide by 15625. Depends on lgsl_pkg.
module lgsl_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dt,
    input  logic [15:0] i_slew,
    output logic        o_done,
    output logic [12:0] o_step
);
    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_MUL  = 4'b0010,
        P_CHK  = 4'b0100,
        P_DIV  = 4'b1000
    } t_phase;

    t_phase      r_ph, n_ph;
    logic        r_cap, n_cap;
    logic [47:0] r_p, n_p;
    logic [25:0] r_rem, n_rem;
    logic [12:0] r_q, n_q;
    logic        r_done, n_done;
    logic [52:0] prod;

    always_comb begin
        n_ph = r_ph;
        n_cap = r_cap;
        n_p = r_p;
        n_rem = r_rem;
        n_q = r_q;
        n_done = 1'b0;
        prod = {27'd0, r_rem} * {26'd0, lgsl_pkg::RECIP_15625};
        case (r_ph)
            P_IDLE: begin
                if (i_start) n_ph = P_MUL;
            end
            P_MUL: begin
                n_cap = (i_slew == 16'd0) || (i_dt >= lgsl_pkg::DT_CAP);
                n_p = 48'(i_slew) * 48'(i_dt[31:0]);
                n_ph = P_CHK;
            end
            P_CHK: begin
                if (r_cap || r_p > lgsl_pkg::P_CAP) begin
                    n_q = lgsl_pkg::UNITY_GAIN;
                    n_done = 1'b1;
                    n_ph = P_IDLE;
                end else begin
                    // 1e6 = 64 * 15625: drop the power of two first
                    n_rem = 26'((r_p + lgsl_pkg::CEIL_ADD) >> 6);
                    n_ph = P_DIV;
                end
            end
            P_DIV: begin
                n_q = prod[52:40];
                n_done = 1'b1;
                n_ph = P_IDLE;
            end
            default: n_ph = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= P_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph <= n_ph;
            r_done <= n_done;
        end
        r_cap <= n_cap;
        r_p <= n_p;
        r_rem <= n_rem;
        r_q <= n_q;
    end

    assign o_done = r_done;
    assign o_step = r_q;
endmodule

@@ bench/tb_led_gain_slew_limiter_unit.sv @@
// Testbench for led_gain_slew_limiter_unit: random and directed requests, checked
// against an in-bench predictor of the gain slew limiter.
// Depends on lgsl_pkg and the led_gain_slew_limiter_unit RTL.
module tb_led_gain_slew_limiter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLED = 256;
    localparam int MAX_CYCLES = 2000000;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  idx;
        logic [15:0] tg;
        logic [63:0] now;
        logic        usable;
        logic        fo;
        logic [7:0]  seg;
    } t_req;

    typedef struct {
        logic        changed;
        logic        settled;
        logic        atten;
        logic [12:0] gain;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = '0;
    logic [7:0]  i_led_index = '0;
    logic [15:0] i_target_gain = '0;
    logic [63:0] i_now_us = '0;
    logic        i_source_usable = 1'b0;
    logic        i_fail_open = 1'b0;
    logic [7:0]  i_segment_id = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        o_changed;
    logic        o_is_settled;
    logic        o_attenuated;
    logic [12:0] o_gain_out;

    led_gain_slew_limiter_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [12:0]     cur_gain [NLED];
    logic [12:0]     goal_gain [NLED];
    longint unsigned last_time = 0;
    bit              inited = 0, settled = 1, atten = 0;
    bit              cur_fo = 0, goal_fo = 0, dirty = 0;
    logic [7:0]      seg_now = '0;
    logic [15:0]     slew = '0;
    logic [8:0]      active = 9'd256;

    t_req pending_reqs[$];
    t_res expected_res[$];
    t_req held;
    int   idle_pct = 13;
    int   cycles = 0;
    bit   failed = 0;

    initial begin
        for (int i = 0; i < NLED; i++) begin
            cur_gain[i] = lgsl_pkg::UNITY_GAIN;
            goal_gain[i] = lgsl_pkg::UNITY_GAIN;
        end
    end

    function automatic int unsigned active_n();
        return (active > NLED) ? NLED : 32'(active);
    endfunction

    function automatic bit goals_unity();
        for (int i = 0; i < active_n(); i++)
            if (goal_gain[i] != lgsl_pkg::UNITY_GAIN) return 0;
        return 1;
    endfunction

    function automatic void snap_unity();
        for (int i = 0; i < NLED; i++) cur_gain[i] = lgsl_pkg::UNITY_GAIN;
    endfunction

    function automatic int unsigned gain_step(longint unsigned dt);
        longint unsigned q, r, raw;
        if (slew == 0) return 4096;
        q = dt / 64'd1000000;
        r = dt % 64'd1000000;
        if (q >= 4096) return 4096;
        raw = slew * q + (slew * r + 64'd999999) / 64'd1000000;
        if (raw == 0 && dt > 0) return 1;
        return (raw > 4096) ? 32'd4096 : 32'(raw);
    endfunction

    function automatic logic [12:0] move_toward(int unsigned c, int unsigned g,
                                                int unsigned s);
        if (c == g || s == 0) return 13'(c);
        if (c < g) return (c + s >= g) ? 13'(g) : 13'(c + s);
        return (c - g <= s) ? 13'(g) : 13'(c - s);
    endfunction

    function automatic bit commit_gains(t_req r);
        bit fo, prof, was;
        fo = !r.usable || r.fo;
        prof = dirty;
        dirty = 0;
        goal_fo = fo;
        if (fo) begin
            was = atten;
            snap_unity();
            cur_fo = 1; seg_now = r.seg; inited = 1; settled = 1; atten = 0;
            last_time = r.now;
            return prof || was;
        end
        if (!inited || cur_fo || seg_now != r.seg) begin
            snap_unity();
            cur_fo = 0; seg_now = r.seg; inited = 1; atten = 0;
            last_time = r.now;
            settled = goals_unity();
            return 1;
        end
        if (prof) settled = 0;
        return prof;
    endfunction

    function automatic bit advance_gains(longint unsigned now);
        int unsigned s;
        logic [12:0] nx;
        bit chg = 0, rem = 0, nonu = 0;
        if (!inited || settled || goal_fo) return 0;
        if (now < last_time) begin
            snap_unity();
            cur_fo = 0; atten = 0;
            settled = goals_unity();
            last_time = now;
            return 1;
        end
        s = gain_step(now - last_time);
        for (int i = 0; i < active_n(); i++) begin
            nx = move_toward(cur_gain[i], goal_gain[i], s);
            if (nx != cur_gain[i]) chg = 1;
            if (nx != goal_gain[i]) rem = 1;
            if (nx != lgsl_pkg::UNITY_GAIN) nonu = 1;
            cur_gain[i] = nx;
        end
        cur_fo = 0;
        atten = nonu;
        settled = !rem;
        last_time = now;
        return chg;
    endfunction

    function automatic t_res limiter_result(t_req r);
        t_res o;
        logic [12:0] g;
        o.changed = 0;
        o.gain = '0;
        case (r.func)
            lgsl_pkg::FUNC_WRITE: begin
                g = (r.tg > lgsl_pkg::UNITY_GAIN) ? lgsl_pkg::UNITY_GAIN : r.tg[12:0];
                if (goal_gain[r.idx] != g) dirty = 1;
                goal_gain[r.idx] = g;
            end
            lgsl_pkg::FUNC_COMMIT:  o.changed = commit_gains(r);
            lgsl_pkg::FUNC_ADVANCE: o.changed = advance_gains(r.now);
            default:                o.gain = cur_gain[r.idx];
        endcase
        o.settled = settled;
        o.atten = atten;
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (start && !busy) expected_res.push_back(limiter_result(held));
            if (!start || !busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    held = pending_reqs.pop_front();
                    start <= 1'b1;
                    i_func <= held.func;
                    i_led_index <= held.idx;
                    i_target_gain <= held.tg;
                    i_now_us <= held.now;
                    i_source_usable <= held.usable;
                    i_fail_open <= held.fo;
                    i_segment_id <= held.seg;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (o_valid) begin
            if (expected_res.size() == 0) begin
                $display("%t: result with none expected: chg=%b set=%b att=%b gain=%0d",
                         $realtime, o_changed, o_is_settled, o_attenuated, o_gain_out);
                failed = 1;
            end else begin
                e = expected_res.pop_front();
                if (o_changed !== e.changed) begin
                    $display("%t: changed exp %b got %b", $realtime, e.changed, o_changed);
                    failed = 1;
                end
                if (o_is_settled !== e.settled) begin
                    $display("%t: is_settled exp %b got %b", $realtime, e.settled,
                             o_is_settled);
                    failed = 1;
                end
                if (o_attenuated !== e.atten) begin
                    $display("%t: attenuated exp %b got %b", $realtime, e.atten,
                             o_attenuated);
                    failed = 1;
                end
                if (o_gain_out !== e.gain) begin
                    $display("%t: gain_out exp %0d got %0d", $realtime, e.gain, o_gain_out);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > MAX_CYCLES) begin
            $display("[led_gain_slew_limiter_unit] ERROR");
            $finish;
        end
    end

    longint unsigned gen_time = 1000;
    logic [7:0]      gen_seg = 8'd3;

    task automatic add_req(int f, int idx, int tg, longint unsigned t,
                           int u, int fo, int seg);
        t_req r;
        r.func = 2'(f); r.idx = 8'(idx); r.tg = 16'(tg); r.now = t;
        r.usable = 1'(u); r.fo = 1'(fo); r.seg = 8'(seg);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_res.size() > 0 || start || busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        slew = (idx == lgsl_pkg::CFG_SLEW) ? val : slew;
        active = (idx == lgsl_pkg::CFG_ACTIVE) ? val[8:0] : active;
    endtask

    // one well-formed burst: goal writes, commit, advances, reads
    task automatic add_burst(int span);
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            add_req(lgsl_pkg::FUNC_WRITE, $urandom_range(span), ($urandom_range(3) == 0) ?
                    $urandom_range(65535) : $urandom_range(4096),
                    {$urandom, $urandom}, $urandom, $urandom, $urandom);
        if ($urandom_range(9) == 0) gen_seg = 8'($urandom);
        add_req(lgsl_pkg::FUNC_COMMIT, $urandom, $urandom, gen_time, 1, 0, gen_seg);
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       gen_time += $urandom_range(3000000, 40000000);
                1, 2:    gen_time += $urandom_range(20000, 500000);
                3:       gen_time += 0;
                default: gen_time += $urandom_range(1, 5000);
            endcase
            add_req(lgsl_pkg::FUNC_ADVANCE, $urandom, $urandom, gen_time, $urandom,
                    $urandom, $urandom);
            if ($urandom_range(2) == 0)
                add_req(lgsl_pkg::FUNC_READ, $urandom_range(span), $urandom,
                        {$urandom, $urandom}, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic add_noise();
        longint unsigned t;
        t = ($urandom_range(3) == 0) ? {$urandom, $urandom} : gen_time;
        if ($urandom_range(4) == 0 && gen_time > 100) t = gen_time - $urandom_range(100);
        add_req($urandom_range(3), $urandom, $urandom, t, $urandom, $urandom,
                ($urandom_range(1) == 0) ? int'(gen_seg) : int'($urandom));
    endtask

    initial begin
        int sent;
        logic [15:0] slews [6];
        logic [15:0] actives [6];
        slews = '{16'd0, 16'd65535, 16'd1, 16'd4096, 16'd300, 16'd20000};
        actives = '{16'd256, 16'd0, 16'd1, 16'd511, 16'd17, 16'd255};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, extremes, snaps, fail-open, time going backwards
        write_reg(lgsl_pkg::CFG_SLEW, 16'd65535);
        add_req(lgsl_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_ADVANCE, 0, 0, 500, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_WRITE, 0, 0, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_WRITE, 255, 65535, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_WRITE, 1, 4097, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_WRITE, 2, 1, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_COMMIT, 0, 0, 1000, 1, 0, 0);
        add_req(lgsl_pkg::FUNC_ADVANCE, 0, 0, 1000, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_ADVANCE, 0, 0, 2000, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_ADVANCE, 0, 0, 500, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_WRITE, 3, 2000, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_COMMIT, 0, 0, 600, 1, 0, 0);
        add_req(lgsl_pkg::FUNC_ADVANCE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_READ, 3, 0, 0, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_COMMIT, 0, 0, 10, 1, 0, 8'hFF);
        add_req(lgsl_pkg::FUNC_COMMIT, 0, 0, 20, 1, 1, 8'hFF);
        add_req(lgsl_pkg::FUNC_ADVANCE, 0, 0, 30, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_COMMIT, 0, 0, 40, 0, 0, 8'hFF);
        add_req(lgsl_pkg::FUNC_COMMIT, 0, 0, 50, 1, 0, 8'hFF);
        add_req(lgsl_pkg::FUNC_ADVANCE, 0, 0, 64'd5000000000, 0, 0, 0);
        add_req(lgsl_pkg::FUNC_READ, 255, 0, 0, 0, 0, 0);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_reg(lgsl_pkg::CFG_SLEW, slews[p]);
            write_reg(lgsl_pkg::CFG_ACTIVE, actives[p]);
            gen_time = 1000;
            idle_pct = (p == 2) ? 0 : 13;
            sent = 0;
            while (sent < 165) begin
                if ($urandom_range(9) < 7) add_burst(($urandom_range(3) == 0) ? 255 : 15);
                else add_noise();
                sent = pending_reqs.size();
            end
            wait_idle();
        end

        repeat (300) @(posedge i_clk);
        if (!failed)
            $display("[led_gain_slew_limiter_unit] OK");
        else
            $display("[led_gain_slew_limiter_unit] ERROR");
        $finish;
    end

endmodule
